>>> src/aftx_pkg.sv
package aftx_pkg;

   // default ring size in bytes
   localparam int unsigned DEPTH_DEFAULT = 512;

   // entries in the command queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_IW    = $clog2(QUEUE_DEPTH);

   // function codes of the request word
   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  data_byte;
      logic        frame_start;
      logic [15:0] frame_len;
   } req_word_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_valid;
      logic        byte_stored;
      logic [31:0] drop_count;
   } rsp_word_type;

   // classified command kinds
   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_POP,
      CMD_START,
      CMD_BYTE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data_byte;
      logic [15:0]  frame_len;
   } cmd_type;

   // handshake from front to back
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_link_type;

endpackage

>>> src/aftx_front.sv
module aftx_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  aftx_pkg::req_word_type req_word,
   output aftx_pkg::cmd_link_type cmd_link,
   input  logic                  cmd_take
);

   localparam int unsigned CW = aftx_pkg::QUEUE_IW + 1;

   aftx_pkg::cmd_type              q_ff [aftx_pkg::QUEUE_DEPTH];
   logic [aftx_pkg::QUEUE_IW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [aftx_pkg::QUEUE_IW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]                  count_ff, count_in;
   aftx_pkg::cmd_type              cmd_new;
   logic                           push;
   logic                           pop;

   // classify the incoming word
   always_comb begin
      cmd_new.data_byte = req_word.data_byte;
      cmd_new.frame_len = req_word.frame_len;
      if (req_word.func == aftx_pkg::FUNC_POP) begin
         cmd_new.kind = aftx_pkg::CMD_POP;
      end else if (req_word.frame_start) begin
         cmd_new.kind = (req_word.frame_len != 16'd0) ? aftx_pkg::CMD_START
                                                      : aftx_pkg::CMD_NOP;
      end else begin
         cmd_new.kind = aftx_pkg::CMD_BYTE;
      end
   end

   assign req_stall = (count_ff == CW'(aftx_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = cmd_take && (count_ff != '0);

   assign cmd_link.valid = (count_ff != '0);
   assign cmd_link.cmd   = q_ff[rd_ptr_ff];

   // advance queue pointers
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // hold queued commands
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

>>> src/aftx_back.sv
module aftx_back #(
   parameter int unsigned DEPTH = aftx_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  aftx_pkg::cmd_link_type cmd_link,
   output logic                  cmd_take,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output aftx_pkg::rsp_word_type rsp_word
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned SW = 17;

   logic [7:0]     mem [DEPTH];
   logic [7:0]     rd_data_ff;

   logic [PW-1:0]  commit_ff, commit_in;
   logic [PW-1:0]  stage_ff, stage_in;
   logic [PW-1:0]  tail_ff, tail_in;
   logic [15:0]    left_ff, left_in;
   logic           open_ff, open_in;
   logic           dropping_ff, dropping_in;
   logic [31:0]    drops_ff, drops_in;

   logic           rsp_valid_ff;
   logic           popped_ff, popped_in;
   logic           stored_ff, stored_in;

   logic           mem_we;
   logic [PW-1:0]  mem_waddr;
   logic           mem_re;

   logic [PW-1:0]  used;
   logic [SW-1:0]  need;
   logic           no_room;
   logic [15:0]    len_less;
   logic [15:0]    left_less;
   logic [PW-1:0]  commit_next;
   logic [PW-1:0]  stage_next;
   logic [PW-1:0]  tail_next;

   function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
      ring_next = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // take a command when the result slot is free or draining
   assign cmd_take = cmd_link.valid && (!rsp_valid_ff || !rsp_stall);

   // committed bytes waiting and admission check
   assign used        = (commit_ff >= tail_ff) ? commit_ff - tail_ff
                                               : commit_ff + PW'(DEPTH) - tail_ff;
   assign need        = {{(SW-PW){1'b0}}, used} + {1'b0, cmd_link.cmd.frame_len};
   assign no_room     = (need >= SW'(DEPTH));
   assign len_less    = cmd_link.cmd.frame_len - 16'd1;
   assign left_less   = left_ff - 16'd1;
   assign commit_next = ring_next(commit_ff);
   assign stage_next  = ring_next(stage_ff);
   assign tail_next   = ring_next(tail_ff);

   // carry out one command
   always_comb begin
      commit_in   = commit_ff;
      stage_in    = stage_ff;
      tail_in     = tail_ff;
      left_in     = left_ff;
      open_in     = open_ff;
      dropping_in = dropping_ff;
      drops_in    = drops_ff;
      popped_in   = 1'b0;
      stored_in   = 1'b0;
      mem_we      = 1'b0;
      mem_waddr   = stage_ff;
      mem_re      = 1'b0;
      if (cmd_take) begin
         case (cmd_link.cmd.kind)
            aftx_pkg::CMD_POP: begin
               if (tail_ff != commit_ff) begin
                  mem_re    = 1'b1;
                  popped_in = 1'b1;
                  tail_in   = tail_next;
               end
            end
            aftx_pkg::CMD_START: begin
               // abandon any unfinished frame, then admit or refuse
               left_in = len_less;
               if (no_room) begin
                  drops_in    = drops_ff + 32'd1;
                  open_in     = 1'b0;
                  dropping_in = (len_less != 16'd0);
                  stage_in    = commit_ff;
               end else begin
                  mem_we      = 1'b1;
                  mem_waddr   = commit_ff;
                  stored_in   = 1'b1;
                  dropping_in = 1'b0;
                  stage_in    = commit_next;
                  if (len_less == 16'd0) begin
                     commit_in = commit_next;
                     open_in   = 1'b0;
                  end else begin
                     open_in = 1'b1;
                  end
               end
            end
            aftx_pkg::CMD_BYTE: begin
               if (dropping_ff) begin
                  left_in     = left_less;
                  dropping_in = (left_less != 16'd0);
               end else if (open_ff) begin
                  mem_we    = 1'b1;
                  stored_in = 1'b1;
                  left_in   = left_less;
                  stage_in  = stage_next;
                  if (left_less == 16'd0) begin
                     commit_in = stage_next;
                     open_in   = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         commit_ff    <= '0;
         stage_ff     <= '0;
         tail_ff      <= '0;
         left_ff      <= '0;
         open_ff      <= 1'b0;
         dropping_ff  <= 1'b0;
         drops_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         popped_ff    <= 1'b0;
         stored_ff    <= 1'b0;
      end else begin
         commit_ff   <= commit_in;
         stage_ff    <= stage_in;
         tail_ff     <= tail_in;
         left_ff     <= left_in;
         open_ff     <= open_in;
         dropping_ff <= dropping_in;
         drops_ff    <= drops_in;
         // load a new result or drop the delivered one
         if (cmd_take) begin
            rsp_valid_ff <= 1'b1;
            popped_ff    <= popped_in;
            stored_ff    <= stored_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // ring storage with registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= cmd_link.cmd.data_byte;
      end
      if (mem_re) begin
         rd_data_ff <= mem[tail_ff];
      end
   end

   // drops_ff only moves when the next result is loaded
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_word.out_byte    = popped_ff ? rd_data_ff : 8'd0;
   assign rsp_word.out_valid   = popped_ff;
   assign rsp_word.byte_stored = stored_ff;
   assign rsp_word.drop_count  = drops_ff;

endmodule

>>> src/atomic_frame_tx_fifo.sv
// Transmit byte ring with all-or-nothing frame admission.
// Request channel (req_valid / req_stall / req_word): each word either pushes
// one frame byte or pops one byte. The first byte of a frame carries
// frame_start and the frame length; a frame that does not fit beside the
// committed bytes is refused whole and counted in drop_count.
// Response channel (rsp_valid / rsp_stall / rsp_word): exactly one word per
// request word, in order, with the popped byte, the stored flag and the
// running drop count. Staged bytes become poppable only after the frame's
// last byte arrives.
// A request word is held in the command queue, then carried out by the back end
// into the registered result word.
// Throughput: one word per cycle while rsp_stall is low, one command at a
// time in the back end; a two-entry command queue separates front and back.
// Stalling rsp holds the result word and fills the queue, after which
// req_stall rises. Reset clears the pointers, counters and queue at once; the
// ring contents are not cleared and are never read before being written.
module atomic_frame_tx_fifo #(
   parameter int unsigned DEPTH = aftx_pkg::DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  aftx_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output aftx_pkg::rsp_word_type rsp_word
);

   aftx_pkg::cmd_link_type cmd_link;
   logic                   cmd_take;

   aftx_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .cmd_link  (cmd_link),
      .cmd_take  (cmd_take)
   );

   aftx_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_link  (cmd_link),
      .cmd_take  (cmd_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

>>> src/aftx_checker.sv
module aftx_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input aftx_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input aftx_pkg::rsp_word_type rsp_word
);

   // no result word right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result word shown right after reset");

   // a stalled request word holds
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_word))
      else $error("stalled request word changed");

   // a stalled result word holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled result word changed");

   // one word never both pops and stores
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_word.out_valid && rsp_word.byte_stored))
      else $error("result word both popped and stored");

   // a word without a popped byte returns zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.out_valid |-> rsp_word.out_byte == 8'd0)
      else $error("out_byte nonzero without a popped byte");

endmodule

bind atomic_frame_tx_fifo aftx_checker u_aftx_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
